>>> hdl/compiled_bitmap_rank_macros.svh
// Assertion macros shared by the compiled bitmap rank design.
`ifndef COMPILED_BITMAP_RANK_MACROS_SVH
`define COMPILED_BITMAP_RANK_MACROS_SVH

// Checks an implication on every rising edge of clk_i, disabled during reset.
`define CBR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks a plain condition on every rising edge of clk_i, disabled during reset.
`define CBR_ASSERT_NOW(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

>>> hdl/cbr_pkg.sv
// Types, constants and the popcount function of the compiled bitmap rank block.
`default_nettype none

package cbr_pkg;

  localparam int unsigned BmWords    = 16;
  localparam int unsigned WordW      = 32;
  localparam int unsigned SlotW      = $clog2(BmWords);
  localparam int unsigned BitW       = $clog2(WordW);
  localparam int unsigned IdxW       = 9;
  localparam int unsigned CntW       = $clog2(WordW + 1);
  localparam int unsigned GroupLanes = 4;
  localparam int unsigned Groups     = BmWords / GroupLanes;
  localparam int unsigned GrpW       = CntW + $clog2(GroupLanes);
  localparam int unsigned SumW       = GrpW + $clog2(Groups);
  localparam int unsigned KindW      = 2;
  localparam int unsigned UsedW      = 5;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_CLASS_KIND   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WORDS_IN_USE = 1'b1;

  // Class kind 0 (none compiled) and the unused code 3 both give empty answers.
  localparam logic [KindW-1:0] KIND_SOME = 2'd1;
  localparam logic [KindW-1:0] KIND_ALL  = 2'd2;

  typedef struct packed {
    logic                func;
    logic [SlotW-1:0]    word_slot;
    logic [WordW-1:0]    word_value;
    logic [IdxW-1:0]     method_index;
  } item_t;

  typedef struct packed {
    logic                compiled;
    logic                has_offset;
    logic [IdxW-1:0]     offset_index;
    logic                range_error;
  } result_t;

  // Bit-parallel population count of one 32-bit word.
  function automatic logic [CntW-1:0] popcount32(input logic [WordW-1:0] v);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    return CntW'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
  endfunction

endpackage

`default_nettype wire

>>> hdl/compiled_bitmap_rank.sv
// Top level of the compiled bitmap rank block: bitmap store and three-stage rank pipeline.
//
// The block takes one item per clock and busy_o stays low. A bitmap word write
// takes effect at its accept edge, so a query accepted in the next cycle sees it.
// A query's result is on res_o with res_valid_o high for one cycle only, once it
// has passed the stage 1, stage 2 and output registers; the receiver cannot
// stall it and must take it then. Writes give no result. The result passes
// through the rank pipeline: masked popcount of every bitmap word, a sum over
// groups of four words, then the final sum and the output register.
`default_nettype none

module compiled_bitmap_rank (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire cbr_pkg::item_t                item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [cbr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cbr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                               res_valid_o,
  output cbr_pkg::result_t                   res_o
);
  import cbr_pkg::*;

  `include "compiled_bitmap_rank_macros.svh"

  logic [KindW-1:0] class_kind_q;
  logic [UsedW-1:0] words_in_use_q;
  logic [WordW-1:0] bitmap_q [BmWords];

  logic accept;
  logic query;

  // Stage 1 signals.
  logic [SlotW-1:0] word_sel;
  logic [BitW-1:0]  bit_sel;
  logic [WordW-1:0] low_mask;
  logic [CntW-1:0]  lane_cnt_d [BmWords];
  logic             hit_d;
  logic             some_d;
  logic             rerr_d;

  logic             s1_valid_q;
  logic             s1_all_q;
  logic             s1_hit_q;
  logic             s1_rerr_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [CntW-1:0]  s1_cnt_q [BmWords];

  logic [GrpW-1:0]  grp_d [Groups];
  logic             s2_valid_q;
  logic             s2_all_q;
  logic             s2_hit_q;
  logic             s2_rerr_q;
  logic [IdxW-1:0]  s2_idx_q;
  logic [GrpW-1:0]  s2_grp_q [Groups];

  logic [SumW-1:0]  sum_d;
  result_t          res_d;
  logic             res_valid_q;
  result_t          res_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign query  = accept && (item_i.func == FUNC_QUERY);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_kind_q   <= '0;
      words_in_use_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLASS_KIND:   class_kind_q   <= cfg_wdata_i[KindW-1:0];
        CFG_WORDS_IN_USE: words_in_use_q <= cfg_wdata_i[UsedW-1:0];
        default: ;
      endcase
    end
  end

  // Bitmap store; words hold no reset value.
  always_ff @(posedge clk_i) begin
    if (accept && (item_i.func == FUNC_WRITE)) begin
      bitmap_q[item_i.word_slot] <= item_i.word_value;
    end
  end

  // Stage 1: every word is masked to the bits below the queried index and counted.
  assign word_sel = item_i.method_index[IdxW-1:BitW];
  assign bit_sel  = item_i.method_index[BitW-1:0];
  assign low_mask = (WordW'(1) << bit_sel) - WordW'(1);
  assign some_d   = (class_kind_q == KIND_SOME);
  assign rerr_d   = some_d && ({1'b0, word_sel} >= words_in_use_q);

  always_comb begin
    hit_d = 1'b0;
    for (int w = 0; w < BmWords; w++) begin
      if (SlotW'(w) < word_sel) begin
        lane_cnt_d[w] = popcount32(bitmap_q[w]);
      end else if (SlotW'(w) == word_sel) begin
        lane_cnt_d[w] = popcount32(bitmap_q[w] & low_mask);
        hit_d         = bitmap_q[w][bit_sel];
      end else begin
        lane_cnt_d[w] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= query;
      s2_valid_q  <= s1_valid_q;
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query) begin
      s1_all_q  <= (class_kind_q == KIND_ALL);
      s1_hit_q  <= some_d && !rerr_d && hit_d;
      s1_rerr_q <= rerr_d;
      s1_idx_q  <= item_i.method_index;
      s1_cnt_q  <= lane_cnt_d;
    end
  end

  // Stage 2: lane counts summed in groups of four.
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_d[g] = '0;
      for (int l = 0; l < GroupLanes; l++) begin
        grp_d[g] = grp_d[g] + GrpW'(s1_cnt_q[g*GroupLanes + l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_all_q  <= s1_all_q;
      s2_hit_q  <= s1_hit_q;
      s2_rerr_q <= s1_rerr_q;
      s2_idx_q  <= s1_idx_q;
      s2_grp_q  <= grp_d;
    end
  end

  // Stage 3: final sum and result selection.
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < Groups; g++) begin
      sum_d = sum_d + SumW'(s2_grp_q[g]);
    end
    res_d.compiled     = s2_all_q || s2_hit_q;
    res_d.has_offset   = s2_all_q || s2_hit_q;
    res_d.range_error  = s2_rerr_q;
    if (s2_all_q) begin
      res_d.offset_index = s2_idx_q;
    end else if (s2_hit_q) begin
      res_d.offset_index = sum_d[IdxW-1:0];
    end else begin
      res_d.offset_index = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `CBR_ASSERT_IMP(a_query_gives_result, query, ##3 res_valid_o,
                  "query transfer lost its result")
  `CBR_ASSERT_IMP(a_result_has_query, res_valid_o, $past(query, 3),
                  "result without a query transfer")
  `CBR_ASSERT_IMP(a_no_offset_is_zero, res_valid_o && !res_o.has_offset,
                  res_o.offset_index == '0, "offset not zero without offset")
  `CBR_ASSERT_IMP(a_range_error_alone, res_valid_o && res_o.range_error,
                  !res_o.compiled && !res_o.has_offset, "range error with compiled method")

endmodule

`default_nettype wire

>>> sim/tb_compiled_bitmap_rank.sv
// Self-checking testbench for the compiled bitmap rank block with a built-in rank predictor.
module tb_compiled_bitmap_rank;
  import cbr_pkg::*;

  localparam int unsigned ResultLatency = 3;
  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned PhaseItems    = 115;

  // The package names only the two kinds that give answers.
  localparam logic [KindW-1:0] KIND_NONE  = 2'd0;
  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  item_t               item_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                res_valid_o;
  result_t             res_o;

  // Predictor copy of the block's state and registers.
  logic [WordW-1:0] bitmap_copy [BmWords];
  logic [KindW-1:0] kind_copy;
  logic [UsedW-1:0] words_copy;
  result_t          expected_answers [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;

  compiled_bitmap_rank uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic result_t rank_lookup(logic [IdxW-1:0] idx);
    result_t     r;
    int unsigned used;
    int unsigned word;
    int unsigned count;
    r = '0;
    if (kind_copy == KIND_ALL) begin
      r.compiled     = 1'b1;
      r.has_offset   = 1'b1;
      r.offset_index = idx;
    end else if (kind_copy == KIND_SOME) begin
      used = (words_copy < BmWords) ? words_copy : BmWords;
      word = idx >> BitW;
      if (word >= used) begin
        r.range_error = 1'b1;
      end else if (bitmap_copy[word][idx[BitW-1:0]]) begin
        count = 0;
        for (int w = 0; w < word; w++) begin
          count += $countones(bitmap_copy[w]);
        end
        count += $countones(bitmap_copy[word] & ((32'd1 << idx[BitW-1:0]) - 32'd1));
        r.compiled     = 1'b1;
        r.has_offset   = 1'b1;
        r.offset_index = count[IdxW-1:0];
      end
    end
    return r;
  endfunction

  function automatic item_t word_write(logic [SlotW-1:0] slot, logic [WordW-1:0] value);
    item_t it;
    it.func         = FUNC_WRITE;
    it.word_slot    = slot;
    it.word_value   = value;
    it.method_index = IdxW'($urandom);
    return it;
  endfunction

  function automatic item_t method_query(logic [IdxW-1:0] idx);
    item_t it;
    it.func         = FUNC_QUERY;
    it.word_slot    = SlotW'($urandom);
    it.word_value   = $urandom;
    it.method_index = idx;
    return it;
  endfunction

  // Sends one item in bursts separated by random gaps; start_i stays high after
  // the transfer so that the next item of a burst follows without a bubble.
  task automatic send_item(item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
    if (it.func == FUNC_WRITE) begin
      bitmap_copy[it.word_slot] = it.word_value;
    end else begin
      expected_answers.push_back(rank_lookup(it.method_index));
    end
  endtask

  // Writes produce no result, so extra cycles after the queue empties cover any item still in flight.
  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (ResultLatency + 2) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [KindW-1:0] kind, logic [UsedW-1:0] words);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CLASS_KIND;
    cfg_wdata_i <= CfgDataW'(kind);
    @(posedge clk_i);
    kind_copy    = kind;
    cfg_idx_i   <= CFG_WORDS_IN_USE;
    cfg_wdata_i <= CfgDataW'(words);
    @(posedge clk_i);
    words_copy = words;
    cfg_we_i  <= 1'b0;
  endtask

  // Reset settings: no bitmap word is read here, since none has been written yet.
  task automatic test_reset_state();
    send_item(method_query('0));
    send_item(method_query('1));
    set_mode(KIND_SOME, 5'd0);
    send_item(method_query('0));
    send_item(method_query('1));
  endtask

  // Every word is loaded before any query that reads the bitmap.
  task automatic test_bitmap_load();
    send_item(word_write(4'd0, '1));
    send_item(word_write(4'd1, '0));
    for (int s = 2; s < BmWords - 1; s++) begin
      send_item(word_write(SlotW'(s), $urandom));
    end
    send_item(word_write(4'(BmWords - 1), '1));
  endtask

  task automatic test_directed_queries();
    set_mode(KIND_SOME, 5'd16);
    send_item(method_query(9'd0));
    send_item(method_query(9'd31));
    send_item(method_query(9'd32));
    send_item(method_query(9'd511));
    // A query right after a word write must see the new word.
    send_item(word_write(4'd2, 32'h0000_0001));
    send_item(method_query(9'd64));
    send_item(method_query(9'd65));
    set_mode(KIND_SOME, 5'd1);
    send_item(method_query(9'd31));
    send_item(method_query(9'd32));
    set_mode(KIND_SOME, 5'd31);
    send_item(method_query(9'd511));
    set_mode(KIND_ALL, 5'd16);
    send_item(method_query(9'd0));
    send_item(method_query(9'd511));
    set_mode(KIND_SPARE, 5'd16);
    send_item(method_query(9'd511));
    set_mode(KIND_NONE, 5'd16);
    send_item(method_query(9'd5));
  endtask

  task automatic test_random_phases();
    logic [KindW-1:0] kinds [8];
    logic [UsedW-1:0] words [8];
    logic [UsedW-1:0] w_now;
    logic [WordW-1:0] value;
    int unsigned      used;
    kinds = '{KIND_SOME, KIND_ALL, KIND_SOME, KIND_NONE, KIND_SOME, KIND_SPARE, KIND_SOME,
              KIND_SOME};
    words = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd0, 5'd16, 5'd0, 5'd0};
    for (int p = 0; p < 8; p++) begin
      w_now = (p >= 6) ? UsedW'($urandom_range(0, 31)) : words[p];
      set_mode(kinds[p], w_now);
      used = (w_now < BmWords) ? w_now : BmWords;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom;
          endcase
          send_item(word_write(SlotW'($urandom), value));
        end else if (used > 0 && $urandom_range(0, 4) != 0) begin
          send_item(method_query(IdxW'($urandom_range(0, used * WordW - 1))));
        end else begin
          send_item(method_query(IdxW'($urandom)));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_answers.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: compiled=%0b has_offset=%0b offset=%0d range_error=%0b",
                   res_o.compiled, res_o.has_offset, res_o.offset_index, res_o.range_error);
        end
        mismatch_count++;
      end else begin
        want = expected_answers.pop_front();
        if (res_o.compiled !== want.compiled || res_o.has_offset !== want.has_offset ||
            res_o.offset_index !== want.offset_index ||
            res_o.range_error !== want.range_error) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected %0b/%0b/%0d/%0b got %0b/%0b/%0d/%0b",
                     want.compiled, want.has_offset, want.offset_index, want.range_error,
                     res_o.compiled, res_o.has_offset, res_o.offset_index, res_o.range_error);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Any transfer, result or register write counts as progress.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    kind_copy   = KIND_NONE;
    words_copy  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_bitmap_load();
    test_directed_queries();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/cbr_pkg.sv
hdl/compiled_bitmap_rank.sv
sim/tb_compiled_bitmap_rank.sv
